### rtl/core/fpe_pkg.sv
package fpe_pkg;

    typedef struct packed {
        logic        start_of_format;
        logic [7:0]  fmt_char;
        logic [63:0] arg_value;
    } fpe_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } fpe_out_t;

    typedef enum logic [1:0] {
        RADIX_8,
        RADIX_10,
        RADIX_16
    } radix_t;

    localparam int unsigned VALUE_W      = 64;
    localparam int unsigned DIV_BITS     = 8;
    localparam int unsigned DIV_CYCLES   = VALUE_W / DIV_BITS;
    localparam logic [4:0]  DECIMAL_BASE = 5'd10;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_FLAG  = 3'd1;
    localparam logic [2:0] PH_WIDTH = 3'd2;
    localparam logic [2:0] PH_SHORT = 3'd3;
    localparam logic [2:0] PH_LONG  = 3'd4;
    localparam logic [2:0] PH_SPEC  = 3'd5;

    localparam logic [2:0] LEN_INT = 3'd0;
    localparam logic [2:0] LEN_H   = 3'd1;
    localparam logic [2:0] LEN_HH  = 3'd2;
    localparam logic [2:0] LEN_L   = 3'd3;
    localparam logic [2:0] LEN_LL  = 3'd4;

    localparam logic [6:0] MAX_WIDTH = 7'd64;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_L       = 8'h6c;
    localparam logic [7:0] CH_O       = 8'h6f;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_X       = 8'h78;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    function automatic logic [7:0] hex_char(input logic [3:0] digit);
        return HEX_DIGITS[digit];
    endfunction

endpackage

### rtl/core/fpe_divider.sv
module fpe_divider (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  fpe_pkg::radix_t      radix,
    input  logic [63:0]          dividend,
    output logic                 done,
    output logic [63:0]          quotient,
    output logic [3:0]           remainder
);
    import fpe_pkg::*;

    localparam int unsigned CntW = $clog2(DIV_CYCLES);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CntW-1:0] step_reg, step_next;
    logic [63:0]     quo_reg, quo_next;
    logic [3:0]      rem_reg, rem_next;
    logic [63:0]     chunk_quo;
    logic [3:0]      chunk_rem;

    // Restoring division by ten, several quotient bits per clock.
    always_comb begin
        logic [4:0]  r;
        logic [63:0] q;
        r = {1'b0, rem_reg};
        q = quo_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            r = {r[3:0], q[63]};
            q = {q[62:0], 1'b0};
            if (r >= DECIMAL_BASE) begin
                r = r - DECIMAL_BASE;
                q[0] = 1'b1;
            end
        end
        chunk_quo = q;
        chunk_rem = r[3:0];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            case (radix)
                RADIX_10: begin
                    busy_next = 1'b1;
                    step_next = '0;
                    quo_next  = dividend;
                    rem_next  = '0;
                end
                RADIX_16: begin
                    done_next = 1'b1;
                    quo_next  = {4'b0, dividend[63:4]};
                    rem_next  = dividend[3:0];
                end
                default: begin
                    done_next = 1'b1;
                    quo_next  = {3'b0, dividend[63:3]};
                    rem_next  = {1'b0, dividend[2:0]};
                end
            endcase
        end else if (busy_reg) begin
            quo_next  = chunk_quo;
            rem_next  = chunk_rem;
            step_next = step_reg + CntW'(1);
            if (step_reg == CntW'(DIV_CYCLES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### rtl/core/format_print_engine_top.sv
// Channel  Direction  Payload    Handshake
// s_       in         fpe_in_t   s_valid / s_ready
// m_       out        fpe_out_t  m_valid / m_ready
//
// Ordinary characters and %c or %% emit one character; parsing characters emit none.
// The shared divider iterates for a decimal digit and shifts for an octal or hex digit.
// Padding, sign and digits then follow; each digit is read from memory before it is sent.
// Reset is synchronous on aresetn and returns the parser to idle.
// The block accepts no new beat until the last character of the current one is in m_data.
module format_print_engine_top #(
    parameter int unsigned DIGIT_SLOTS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fpe_pkg::fpe_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output fpe_pkg::fpe_out_t m_data
);
    import fpe_pkg::*;

    localparam int unsigned PosW  = $clog2(DIGIT_SLOTS + 1);
    localparam int unsigned AddrW = $clog2(DIGIT_SLOTS);
    localparam int unsigned CmpW  = (PosW + 1 > 7) ? PosW + 1 : 7;

    typedef enum logic [3:0] {
        S_IDLE, S_ONE, S_NEG, S_DIV, S_WAIT, S_LEN, S_PAD, S_SIGN, S_RADDR, S_DOUT
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE, ACT_CHAR, ACT_NUM
    } act_t;

    state_t          state_reg, state_next;
    logic [2:0]      phase_reg, phase_next;
    logic [2:0]      len_reg, len_next;
    logic [6:0]      width_reg, width_next;
    logic            zpad_reg, zpad_next;
    logic [7:0]      char_reg, char_next;
    logic [63:0]     quotient_reg, quotient_next;
    logic            neg_reg, neg_next;
    logic            wide_reg, wide_next;
    radix_t          radix_reg, radix_next;
    logic [6:0]      cwidth_reg, cwidth_next;
    logic            czpad_reg, czpad_next;
    logic [PosW-1:0] pos_reg, pos_next;
    logic [6:0]      pad_reg, pad_next;
    logic            m_valid_reg, m_valid_next;
    fpe_out_t        m_data_reg, m_data_next;

    logic [3:0]      digit_mem [DIGIT_SLOTS];
    logic [3:0]      rd_data_reg;
    logic            wr_en, rd_en;
    logic [PosW-1:0] pos_dec;

    logic            div_start, div_done;
    logic [63:0]     div_quo;
    logic [3:0]      div_rem;

    logic            accept, out_free;
    logic [7:0]      c;
    logic [2:0]      ph, p_phase, p_len, eff_len;
    logic [6:0]      p_width, eff_width;
    logic            p_zpad, eff_zpad;
    logic            do_conv, act_signed;
    act_t            act;
    logic [7:0]      act_char;
    radix_t          act_radix;
    logic [9:0]      w_mul;
    logic            is_digit;
    logic [63:0]     load_val;
    logic            load_wide;
    logic [CmpW-1:0] num_len;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign c        = s_data.fmt_char;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign w_mul    = {width_reg, 3'b000} + {2'b00, width_reg, 1'b0} + {6'b0, c[3:0]};
    assign pos_dec  = pos_reg - PosW'(1);

    // Format parser for one character.
    always_comb begin
        ph        = s_data.start_of_format ? PH_IDLE : phase_reg;
        eff_len   = s_data.start_of_format ? LEN_INT : len_reg;
        eff_width = s_data.start_of_format ? 7'd0 : width_reg;
        eff_zpad  = s_data.start_of_format ? 1'b0 : zpad_reg;
        p_phase    = ph;
        p_len      = eff_len;
        p_width    = eff_width;
        p_zpad     = eff_zpad;
        do_conv    = 1'b0;
        act        = ACT_NONE;
        act_char   = c;
        act_radix  = RADIX_10;
        act_signed = 1'b0;
        if (c == CH_NUL) begin
            p_phase = PH_IDLE;
            p_len   = LEN_INT;
            p_width = 7'd0;
            p_zpad  = 1'b0;
        end else begin
            case (ph)
                PH_IDLE: begin
                    if (c == CH_PERCENT) begin
                        p_phase = PH_FLAG;
                        p_width = 7'd0;
                        p_zpad  = 1'b0;
                    end else begin
                        act = ACT_CHAR;
                    end
                end
                PH_FLAG, PH_WIDTH: begin
                    if (ph == PH_FLAG && c == CH_ZERO) begin
                        p_zpad  = 1'b1;
                        p_phase = PH_WIDTH;
                    end else if (ph == PH_FLAG && c >= CH_ONE && c <= CH_NINE) begin
                        p_width = {3'b0, c[3:0]};
                        p_phase = PH_WIDTH;
                    end else if (ph == PH_WIDTH && is_digit) begin
                        p_width = (w_mul > {3'b0, MAX_WIDTH}) ? MAX_WIDTH : w_mul[6:0];
                    end else if (c == CH_H) begin
                        p_len   = LEN_H;
                        p_phase = PH_SHORT;
                    end else if (c == CH_L) begin
                        p_len   = LEN_L;
                        p_phase = PH_LONG;
                    end else begin
                        do_conv = 1'b1;
                    end
                end
                PH_SHORT: begin
                    if (c == CH_H) begin
                        p_len   = LEN_HH;
                        p_phase = PH_SPEC;
                    end else begin
                        do_conv = 1'b1;
                    end
                end
                PH_LONG: begin
                    if (c == CH_L) begin
                        p_len   = LEN_LL;
                        p_phase = PH_SPEC;
                    end else begin
                        do_conv = 1'b1;
                    end
                end
                default: do_conv = 1'b1;
            endcase
            if (do_conv) begin
                p_phase = PH_IDLE;
                p_len   = LEN_INT;
                p_width = 7'd0;
                p_zpad  = 1'b0;
                case (c)
                    CH_C: begin
                        act      = ACT_CHAR;
                        act_char = s_data.arg_value[7:0];
                    end
                    CH_PERCENT: act = ACT_CHAR;
                    CH_D, CH_I: begin
                        act        = ACT_NUM;
                        act_signed = 1'b1;
                    end
                    CH_U: act = ACT_NUM;
                    CH_X, CH_UPPER_X, CH_P: begin
                        act       = ACT_NUM;
                        act_radix = RADIX_16;
                    end
                    CH_O: begin
                        act       = ACT_NUM;
                        act_radix = RADIX_8;
                    end
                    default: act = ACT_NONE;
                endcase
            end
        end
    end

    assign load_wide = (eff_len == LEN_LL);
    assign load_val  = load_wide ? s_data.arg_value : {32'b0, s_data.arg_value[31:0]};
    assign num_len   = CmpW'(pos_reg) + CmpW'(neg_reg);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        len_next      = len_reg;
        width_next    = width_reg;
        zpad_next     = zpad_reg;
        char_next     = char_reg;
        quotient_next = quotient_reg;
        neg_next      = neg_reg;
        wide_next     = wide_reg;
        radix_next    = radix_reg;
        cwidth_next   = cwidth_reg;
        czpad_next    = czpad_reg;
        pos_next      = pos_reg;
        pad_next      = pad_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        div_start     = 1'b0;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    phase_next = p_phase;
                    len_next   = p_len;
                    width_next = p_width;
                    zpad_next  = p_zpad;
                    case (act)
                        ACT_CHAR: begin
                            char_next  = act_char;
                            state_next = S_ONE;
                        end
                        ACT_NUM: begin
                            quotient_next = load_val;
                            wide_next     = load_wide;
                            neg_next      = act_signed && (load_wide ? s_data.arg_value[63]
                                                                     : s_data.arg_value[31]);
                            radix_next    = act_radix;
                            cwidth_next   = eff_width;
                            czpad_next    = eff_zpad;
                            state_next    = S_NEG;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: char_reg, last: 1'b1};
                    state_next   = S_IDLE;
                end
            end
            S_NEG: begin
                if (neg_reg) begin
                    quotient_next = 64'd0 - quotient_reg;
                    if (!wide_reg) begin
                        quotient_next[63:32] = 32'b0;
                    end
                end
                pos_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    wr_en         = 1'b1;
                    pos_next      = pos_reg + PosW'(1);
                    quotient_next = div_quo;
                    if (div_quo == 64'd0 || pos_next == PosW'(DIGIT_SLOTS)) begin
                        state_next = S_LEN;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_LEN: begin
                pad_next   = (CmpW'(cwidth_reg) > num_len) ? 7'(CmpW'(cwidth_reg) - num_len)
                                                           : 7'd0;
                state_next = S_PAD;
            end
            S_PAD: begin
                if (pad_reg == 7'd0) begin
                    state_next = neg_reg ? S_SIGN : S_RADDR;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: (czpad_reg ? CH_ZERO : CH_SPACE), last: 1'b0};
                    pad_next     = pad_reg - 7'd1;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: CH_MINUS, last: 1'b0};
                    state_next   = S_RADDR;
                end
            end
            S_RADDR: begin
                rd_en      = 1'b1;
                pos_next   = pos_dec;
                state_next = S_DOUT;
            end
            S_DOUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_char: hex_char(rd_data_reg), last: (pos_reg == '0)};
                    state_next   = (pos_reg == '0) ? S_IDLE : S_RADDR;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        char_reg     <= char_next;
        quotient_reg <= quotient_next;
        neg_reg      <= neg_next;
        wide_reg     <= wide_next;
        radix_reg    <= radix_next;
        cwidth_reg   <= cwidth_next;
        czpad_reg    <= czpad_next;
        pos_reg      <= pos_next;
        pad_reg      <= pad_next;
        m_data_reg   <= m_data_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_IDLE;
            len_reg     <= LEN_INT;
            width_reg   <= 7'd0;
            zpad_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            width_reg   <= width_next;
            zpad_reg    <= zpad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_mem[pos_reg[AddrW-1:0]] <= div_rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= digit_mem[pos_dec[AddrW-1:0]];
        end
    end

    fpe_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .radix     (radix_reg),
        .dividend  (quotient_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
